>>> hw/rtl/quaternion_weight_skinning_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion weight skinning block
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// They expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_WEIGHT_SKINNING_ASSERT_SVH
`define QUATERNION_WEIGHT_SKINNING_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define QWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication
`define QWS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define QWS_ASSERT_IMP(label, ante, cons)
`define QWS_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> hw/rtl/qws_pkg.sv
// ----------------------------------------------------------------------------
// qws_pkg
// Beat types, datapath widths and the sequencer microcode for the
// quaternion weight skinning block.
// ----------------------------------------------------------------------------
package qws_pkg;

    // Field widths
    localparam int Q_W    = 16;   // quaternion component, Q1.14
    localparam int P_W    = 32;   // position component, Q16.16
    localparam int BIAS_W = 17;   // influence, unsigned Q1.16

    // Datapath widths
    localparam int OPA_W  = 40;             // multiplier A: v, t or J + r
    localparam int OPB_W  = 18;             // multiplier B: u, w or bias
    localparam int PROD_W = OPA_W + OPB_W;  // full product
    localparam int ACC_W  = PROD_W;         // accumulator
    localparam int T_W    = 36;             // t = 2 (v x u), rounded
    localparam int JR_W   = OPA_W;          // J + r
    localparam int SUM_W  = 48;             // running vertex sum

    // Sequencer
    localparam int STEP_W    = 5;
    localparam int IDX_W     = 2;
    localparam int LAST_STEP = 19;

    // Rounding offsets (half of the LSB kept) and shifts
    localparam logic signed [ACC_W-1:0] RBIAS_T = ACC_W'(4096);
    localparam logic signed [ACC_W-1:0] RBIAS_R = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] RBIAS_C = ACC_W'(32768);
    localparam int SH_T = 13;   // rnd(2x, 14) == rnd(x, 13)
    localparam int SH_R = 14;
    localparam int SH_C = 16;

    // Input beat
    typedef struct packed {
        logic signed [Q_W-1:0]  joint_qx;
        logic signed [Q_W-1:0]  joint_qy;
        logic signed [Q_W-1:0]  joint_qz;
        logic signed [Q_W-1:0]  joint_qw;
        logic signed [P_W-1:0]  joint_px;
        logic signed [P_W-1:0]  joint_py;
        logic signed [P_W-1:0]  joint_pz;
        logic signed [P_W-1:0]  weight_px;
        logic signed [P_W-1:0]  weight_py;
        logic signed [P_W-1:0]  weight_pz;
        logic [BIAS_W-1:0]      influence;
        logic                   last_weight;
    } weight_t;

    // Output beat
    typedef struct packed {
        logic signed [P_W-1:0] vertex_x;
        logic signed [P_W-1:0] vertex_y;
        logic signed [P_W-1:0] vertex_z;
    } vertex_t;

    typedef enum logic [1:0] {A_V, A_T, A_JR} a_sel_t;
    typedef enum logic [1:0] {B_U, B_W, B_BIAS} b_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {RND_T, RND_R, RND_C} rnd_sel_t;
    typedef enum logic [2:0] {WB_NONE, WB_T, WB_E, WB_F, WB_C, WB_EMIT} wb_op_t;

    // One microcode word: multiplier issue, accumulate, write back
    typedef struct packed {
        a_sel_t             a_sel;
        logic [IDX_W-1:0]   a_idx;
        b_sel_t             b_sel;
        logic [IDX_W-1:0]   b_idx;
        acc_op_t            acc_op;
        rnd_sel_t           rnd_sel;
        wb_op_t             wb_op;
        logic [IDX_W-1:0]   wb_idx;
    } uop_t;

    // Sequencer to datapath
    typedef struct packed {
        uop_t   uop;
        logic   emit_fire;
    } ctl_t;

    localparam uop_t UOP_IDLE = '{
        a_sel: A_V, a_idx: '0, b_sel: B_U, b_idx: '0,
        acc_op: ACC_HOLD, rnd_sel: RND_T, wb_op: WB_NONE, wb_idx: '0
    };

    // Microcode. A product issued at one step is accumulated at the next; a finished
    // chain is written back at the step after its last accumulate.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        u = UOP_IDLE;
        // multiplier operands
        unique case (step)
            5'd0:  begin u.a_sel = A_V;  u.a_idx = 2'd1; u.b_sel = B_U; u.b_idx = 2'd2; end
            5'd1:  begin u.a_sel = A_V;  u.a_idx = 2'd2; u.b_sel = B_U; u.b_idx = 2'd1; end
            5'd2:  begin u.a_sel = A_V;  u.a_idx = 2'd2; u.b_sel = B_U; u.b_idx = 2'd0; end
            5'd3:  begin u.a_sel = A_V;  u.a_idx = 2'd0; u.b_sel = B_U; u.b_idx = 2'd2; end
            5'd4:  begin u.a_sel = A_V;  u.a_idx = 2'd0; u.b_sel = B_U; u.b_idx = 2'd1; end
            5'd5:  begin u.a_sel = A_V;  u.a_idx = 2'd1; u.b_sel = B_U; u.b_idx = 2'd0; end
            5'd6:  begin u.a_sel = A_T;  u.a_idx = 2'd0; u.b_sel = B_W; end
            5'd7:  begin u.a_sel = A_T;  u.a_idx = 2'd1; u.b_sel = B_U; u.b_idx = 2'd2; end
            5'd8:  begin u.a_sel = A_T;  u.a_idx = 2'd2; u.b_sel = B_U; u.b_idx = 2'd1; end
            5'd9:  begin u.a_sel = A_T;  u.a_idx = 2'd1; u.b_sel = B_W; end
            5'd10: begin u.a_sel = A_T;  u.a_idx = 2'd2; u.b_sel = B_U; u.b_idx = 2'd0; end
            5'd11: begin u.a_sel = A_T;  u.a_idx = 2'd0; u.b_sel = B_U; u.b_idx = 2'd2; end
            5'd12: begin u.a_sel = A_T;  u.a_idx = 2'd2; u.b_sel = B_W; end
            5'd13: begin u.a_sel = A_T;  u.a_idx = 2'd0; u.b_sel = B_U; u.b_idx = 2'd1; end
            5'd14: begin u.a_sel = A_T;  u.a_idx = 2'd1; u.b_sel = B_U; u.b_idx = 2'd0; end
            5'd15: begin u.a_sel = A_JR; u.a_idx = 2'd0; u.b_sel = B_BIAS; end
            5'd16: begin u.a_sel = A_JR; u.a_idx = 2'd1; u.b_sel = B_BIAS; end
            5'd17: begin u.a_sel = A_JR; u.a_idx = 2'd2; u.b_sel = B_BIAS; end
            default: ;
        endcase
        // accumulator
        unique case (step)
            5'd1, 5'd3, 5'd5:
                begin u.acc_op = ACC_LOAD; u.rnd_sel = RND_T; end
            5'd7, 5'd8, 5'd10, 5'd11, 5'd13, 5'd14:
                begin u.acc_op = ACC_LOAD; u.rnd_sel = RND_R; end
            5'd16, 5'd17, 5'd18:
                begin u.acc_op = ACC_LOAD; u.rnd_sel = RND_C; end
            5'd2, 5'd4, 5'd6, 5'd9, 5'd12, 5'd15:
                u.acc_op = ACC_SUB;
            default: ;
        endcase
        // write back
        unique case (step)
            5'd3:  begin u.wb_op = WB_T; u.wb_idx = 2'd0; end
            5'd5:  begin u.wb_op = WB_T; u.wb_idx = 2'd1; end
            5'd7:  begin u.wb_op = WB_T; u.wb_idx = 2'd2; end
            5'd8:  begin u.wb_op = WB_E; u.wb_idx = 2'd0; end
            5'd10: begin u.wb_op = WB_F; u.wb_idx = 2'd0; end
            5'd11: begin u.wb_op = WB_E; u.wb_idx = 2'd1; end
            5'd13: begin u.wb_op = WB_F; u.wb_idx = 2'd1; end
            5'd14: begin u.wb_op = WB_E; u.wb_idx = 2'd2; end
            5'd16: begin u.wb_op = WB_F; u.wb_idx = 2'd2; end
            5'd17: begin u.wb_op = WB_C; u.wb_idx = 2'd0; end
            5'd18: begin u.wb_op = WB_C; u.wb_idx = 2'd1; end
            5'd19: begin u.wb_op = WB_C; u.wb_idx = 2'd2; end
            default: ;
        endcase
        return u;
    endfunction

endpackage

>>> hw/rtl/qws_mac.sv
// ----------------------------------------------------------------------------
// qws_mac
// Shared 40x18 signed multiplier with a registered product, followed by an
// accumulator that loads with a rounding offset, adds or subtracts.
// ----------------------------------------------------------------------------
module qws_mac (
    input  logic                                clk,
    input  logic signed [qws_pkg::OPA_W-1:0]    a,
    input  logic signed [qws_pkg::OPB_W-1:0]    b,
    input  qws_pkg::acc_op_t                    acc_op,
    input  qws_pkg::rnd_sel_t                   rnd_sel,
    output logic signed [qws_pkg::ACC_W-1:0]    acc
);

    logic signed [qws_pkg::PROD_W-1:0] prod_reg;
    logic signed [qws_pkg::PROD_W-1:0] prod_next;
    logic signed [qws_pkg::ACC_W-1:0]  acc_reg;
    logic signed [qws_pkg::ACC_W-1:0]  acc_next;
    logic signed [qws_pkg::ACC_W-1:0]  rbias;

    // multiply stage
    assign prod_next = a * b;

    // rounding offset for the head of a chain
    always_comb
    begin
        case (rnd_sel)
            qws_pkg::RND_T: rbias = qws_pkg::RBIAS_T;
            qws_pkg::RND_R: rbias = qws_pkg::RBIAS_R;
            qws_pkg::RND_C: rbias = qws_pkg::RBIAS_C;
            default:        rbias = qws_pkg::RBIAS_T;
        endcase
    end

    // accumulate stage
    always_comb
    begin
        case (acc_op)
            qws_pkg::ACC_LOAD: acc_next = prod_reg + rbias;
            qws_pkg::ACC_ADD:  acc_next = acc_reg + prod_reg;
            qws_pkg::ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:           acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

>>> hw/rtl/qws_ctrl.sv
// ----------------------------------------------------------------------------
// qws_ctrl
// Step sequencer: walks the microcode for one weight beat, then holds in the
// emit step until the output register can take a vertex.
// ----------------------------------------------------------------------------
module qws_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            out_busy,
    output logic            ready,
    output qws_pkg::ctl_t   ctl
);

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_EMIT} state_t;

    state_t                         state_reg;
    logic [qws_pkg::STEP_W-1:0]     step_reg;
    logic                           ready_reg;

    // state, step counter and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_RUN;
                        step_reg  <= '0;
                        ready_reg <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (step_reg == qws_pkg::STEP_W'(qws_pkg::LAST_STEP))
                        state_reg <= ST_EMIT;
                    else
                        step_reg <= step_reg + qws_pkg::STEP_W'(1);
                end
                ST_EMIT:
                begin
                    if (!out_busy)
                    begin
                        state_reg <= ST_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // microcode decode
    always_comb
    begin
        ctl.uop       = qws_pkg::UOP_IDLE;
        ctl.emit_fire = 1'b0;
        unique case (state_reg)
            ST_RUN:  ctl.uop = qws_pkg::uop_at(step_reg);
            ST_EMIT:
            begin
                ctl.uop.wb_op = qws_pkg::WB_EMIT;
                ctl.emit_fire = !out_busy;
            end
            default: ;
        endcase
    end

    assign ready = ready_reg;

endmodule

>>> hw/rtl/quaternion_weight_skinning.sv
// A vertex beat becomes valid after its last weight beat has run through the microcode
//   and its emit step. A new weight beat is taken only after the previous one leaves its
//   emit step; the single shared multiplier issues 18 products per weight.
// A last weight waits in its emit step while an earlier vertex is still unread.
// Reset (rst_n low, asynchronous) clears the running sum, the sequencer and the
//   output valid; the block is ready for a weight right after reset.
// ----------------------------------------------------------------------------
// quaternion_weight_skinning
// Rotates each weight position by the joint quaternion, offsets it by the
// joint position, scales by the bias and sums into a vertex position, which is
// emitted saturated to Q16.16 on the last weight.
// ----------------------------------------------------------------------------
`include "quaternion_weight_skinning_assert.svh"

module quaternion_weight_skinning (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                weight_valid,
    output logic                weight_ready,
    input  qws_pkg::weight_t    weight,
    output logic                vertex_valid,
    input  logic                vertex_ready,
    output qws_pkg::vertex_t    vertex
);

    qws_pkg::weight_t                       in_reg;
    qws_pkg::ctl_t                          ctl;
    logic                                   out_busy;

    logic signed [qws_pkg::P_W-1:0]         v_arr [3];
    logic signed [qws_pkg::P_W-1:0]         j_arr [3];
    logic signed [qws_pkg::Q_W-1:0]         u_arr [3];

    logic signed [qws_pkg::OPA_W-1:0]       op_a;
    logic signed [qws_pkg::OPB_W-1:0]       op_b;
    logic signed [qws_pkg::ACC_W-1:0]       acc;

    logic signed [qws_pkg::T_W-1:0]         t_reg [3];
    logic signed [qws_pkg::JR_W-1:0]        s_reg;
    logic signed [qws_pkg::JR_W-1:0]        s_next;
    logic signed [qws_pkg::JR_W-1:0]        jr_reg [3];
    logic signed [qws_pkg::JR_W-1:0]        jr_next;
    logic signed [qws_pkg::JR_W-1:0]        r_term;
    logic signed [qws_pkg::SUM_W-1:0]       sum_reg [3];
    logic signed [qws_pkg::SUM_W-1:0]       sum_next;
    logic signed [qws_pkg::SUM_W:0]         sum_wide;

    qws_pkg::vertex_t                       vertex_reg;
    logic                                   vertex_valid_reg;
    logic                                   emit_last;

    // saturate a widened sum back to the sum width
    function automatic logic signed [qws_pkg::SUM_W-1:0] sat_sum(
        input logic signed [qws_pkg::SUM_W:0] x
    );
        if (x[qws_pkg::SUM_W] != x[qws_pkg::SUM_W-1])
            return x[qws_pkg::SUM_W] ? {1'b1, {(qws_pkg::SUM_W-1){1'b0}}}
                                     : {1'b0, {(qws_pkg::SUM_W-1){1'b1}}};
        return x[qws_pkg::SUM_W-1:0];
    endfunction

    // saturate a sum to the Q16.16 output range
    function automatic logic signed [qws_pkg::P_W-1:0] sat_out(
        input logic signed [qws_pkg::SUM_W-1:0] x
    );
        if ((&x[qws_pkg::SUM_W-1:qws_pkg::P_W-1]) || !(|x[qws_pkg::SUM_W-1:qws_pkg::P_W-1]))
            return x[qws_pkg::P_W-1:0];
        return x[qws_pkg::SUM_W-1] ? {1'b1, {(qws_pkg::P_W-1){1'b0}}}
                                   : {1'b0, {(qws_pkg::P_W-1){1'b1}}};
    endfunction

    // sequencer
    assign out_busy  = in_reg.last_weight && vertex_valid_reg && !vertex_ready;
    assign emit_last = ctl.emit_fire && in_reg.last_weight;

    qws_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (weight_valid && weight_ready),
        .out_busy (out_busy),
        .ready    (weight_ready),
        .ctl      (ctl)
    );

    // input beat register
    always_ff @(posedge clk)
    begin
        if (weight_valid && weight_ready)
            in_reg <= weight;
    end

    assign v_arr[0] = in_reg.weight_px;
    assign v_arr[1] = in_reg.weight_py;
    assign v_arr[2] = in_reg.weight_pz;
    assign j_arr[0] = in_reg.joint_px;
    assign j_arr[1] = in_reg.joint_py;
    assign j_arr[2] = in_reg.joint_pz;
    assign u_arr[0] = in_reg.joint_qx;
    assign u_arr[1] = in_reg.joint_qy;
    assign u_arr[2] = in_reg.joint_qz;

    // multiplier operand select
    always_comb
    begin
        case (ctl.uop.a_sel)
            qws_pkg::A_T:  op_a = qws_pkg::OPA_W'(t_reg[ctl.uop.a_idx]);
            qws_pkg::A_JR: op_a = jr_reg[ctl.uop.a_idx];
            default:       op_a = qws_pkg::OPA_W'(v_arr[ctl.uop.a_idx]);
        endcase
        case (ctl.uop.b_sel)
            qws_pkg::B_W:    op_b = qws_pkg::OPB_W'(in_reg.joint_qw);
            qws_pkg::B_BIAS: op_b = signed'({1'b0, in_reg.influence});
            default:         op_b = qws_pkg::OPB_W'(u_arr[ctl.uop.b_idx]);
        endcase
    end

    qws_mac u_mac (
        .clk     (clk),
        .a       (op_a),
        .b       (op_b),
        .acc_op  (ctl.uop.acc_op),
        .rnd_sel (ctl.uop.rnd_sel),
        .acc     (acc)
    );

    // write-back arithmetic: r = v + rnd(w t) + rnd(t x u), kept as J + r
    assign r_term  = qws_pkg::JR_W'(acc >>> qws_pkg::SH_R);
    assign s_next  = qws_pkg::JR_W'(v_arr[ctl.uop.wb_idx])
                   + qws_pkg::JR_W'(j_arr[ctl.uop.wb_idx]) + r_term;
    assign jr_next = s_reg + r_term;

    // contribution into the running sum
    assign sum_wide = (qws_pkg::SUM_W + 1)'(sum_reg[ctl.uop.wb_idx]) // sign kept
                    + (qws_pkg::SUM_W + 1)'(acc >>> qws_pkg::SH_C);
    assign sum_next = sat_sum(sum_wide);

    // intermediate registers
    always_ff @(posedge clk)
    begin
        case (ctl.uop.wb_op)
            qws_pkg::WB_T: t_reg[ctl.uop.wb_idx] <= qws_pkg::T_W'(acc >>> qws_pkg::SH_T);
            qws_pkg::WB_E: s_reg <= s_next;
            qws_pkg::WB_F: jr_reg[ctl.uop.wb_idx] <= jr_next;
            default: ;
        endcase
    end

    // running vertex sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end
        else if (emit_last)
        begin
            sum_reg[0] <= '0;
            sum_reg[1] <= '0;
            sum_reg[2] <= '0;
        end
        else if (ctl.uop.wb_op == qws_pkg::WB_C)
        begin
            sum_reg[ctl.uop.wb_idx] <= sum_next;
        end
    end

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vertex_valid_reg <= 1'b0;
        else if (emit_last)
            vertex_valid_reg <= 1'b1;
        else if (vertex_ready)
            vertex_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_last)
        begin
            vertex_reg.vertex_x <= sat_out(sum_reg[0]);
            vertex_reg.vertex_y <= sat_out(sum_reg[1]);
            vertex_reg.vertex_z <= sat_out(sum_reg[2]);
        end
    end

    assign vertex_valid = vertex_valid_reg;
    assign vertex       = vertex_reg;

    // checks
    `QWS_ASSERT_NXT(a_busy_after_accept, weight_valid && weight_ready, !weight_ready)
    `QWS_ASSERT_NXT(a_emit_sets_valid, emit_last, vertex_valid)
    `QWS_ASSERT_NXT(a_emit_clears_sum, emit_last, (sum_reg[0] == '0) && (sum_reg[1] == '0) && (sum_reg[2] == '0))
    `QWS_ASSERT_IMP(a_no_overwrite, emit_last && vertex_valid, vertex_ready)
    `QWS_ASSERT_NXT(a_stall_holds_emit, (ctl.uop.wb_op == qws_pkg::WB_EMIT) && !ctl.emit_fire, !weight_ready)

endmodule

>>> test/quaternion_weight_skinning_tb.sv
// ----------------------------------------------------------------------------
// quaternion_weight_skinning_tb
// Streams joint weights into the skinning block and checks each emitted vertex
// against a bit-exact fixed-point blend computed inside the bench. Both
// handshakes idle and stall at random; one long vertex drives the 48-bit sum
// into saturation.
// ----------------------------------------------------------------------------
module quaternion_weight_skinning_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Running blend of weights into vertices, and vertices still owed
    class skinned_vertex_board;
        localparam longint SUM_MAX = (longint'(1) <<< 47) - 1;
        localparam longint SUM_MIN = -(longint'(1) <<< 47);
        localparam longint OUT_MAX = 64'sd2147483647;
        localparam longint OUT_MIN = -64'sd2147483648;

        longint           blend_sum[3];
        qws_pkg::vertex_t due_vertices[$];
        int               errors;

        // round half up, then drop s fraction bits
        function longint rnd(longint x, int s);
            return (x + (longint'(1) <<< (s - 1))) >>> s;
        endfunction

        function longint clamp(longint x, longint lo, longint hi);
            return (x < lo) ? lo : ((x > hi) ? hi : x);
        endfunction

        // Fold one weight into the sum; a last weight owes a vertex
        function void add_weight(qws_pkg::weight_t wb);
            longint           u[3], v[3], jp[3], t[3], r[3];
            longint           qw, bias, c;
            qws_pkg::vertex_t vx;
            u[0]  = $signed(wb.joint_qx);
            u[1]  = $signed(wb.joint_qy);
            u[2]  = $signed(wb.joint_qz);
            qw    = $signed(wb.joint_qw);
            jp[0] = $signed(wb.joint_px);
            jp[1] = $signed(wb.joint_py);
            jp[2] = $signed(wb.joint_pz);
            v[0]  = $signed(wb.weight_px);
            v[1]  = $signed(wb.weight_py);
            v[2]  = $signed(wb.weight_pz);
            bias  = wb.influence;

            // t = 2 (v x u)
            t[0] = rnd(2 * (v[1] * u[2] - v[2] * u[1]), 14);
            t[1] = rnd(2 * (v[2] * u[0] - v[0] * u[2]), 14);
            t[2] = rnd(2 * (v[0] * u[1] - v[1] * u[0]), 14);

            // r = v + w t + t x u
            r[0] = v[0] + rnd(qw * t[0], 14) + rnd(t[1] * u[2] - t[2] * u[1], 14);
            r[1] = v[1] + rnd(qw * t[1], 14) + rnd(t[2] * u[0] - t[0] * u[2], 14);
            r[2] = v[2] + rnd(qw * t[2], 14) + rnd(t[0] * u[1] - t[1] * u[0], 14);

            for (int i = 0; i < 3; i++)
            begin
                c = rnd((jp[i] + r[i]) * bias, 16);
                blend_sum[i] = clamp(blend_sum[i] + c, SUM_MIN, SUM_MAX);
            end

            if (!wb.last_weight)
                return;

            vx.vertex_x = 32'(clamp(blend_sum[0], OUT_MIN, OUT_MAX));
            vx.vertex_y = 32'(clamp(blend_sum[1], OUT_MIN, OUT_MAX));
            vx.vertex_z = 32'(clamp(blend_sum[2], OUT_MIN, OUT_MAX));
            due_vertices = {due_vertices, vx};
            for (int i = 0; i < 3; i++)
                blend_sum[i] = 0;
        endfunction

        function void compare(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] got_v);
            if (exp_v !== got_v)
            begin
                $display("%0t: %s expected %0d got %0d", $realtime, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // Match an emitted vertex against the oldest one owed
        function void check_vertex(qws_pkg::vertex_t got);
            qws_pkg::vertex_t exp_v;
            if (due_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex expected none got %0d %0d %0d",
                         $realtime, got.vertex_x, got.vertex_y, got.vertex_z);
                errors++;
                return;
            end
            exp_v = due_vertices.pop_front();
            compare("vertex_x", exp_v.vertex_x, got.vertex_x);
            compare("vertex_y", exp_v.vertex_y, got.vertex_y);
            compare("vertex_z", exp_v.vertex_z, got.vertex_z);
        endfunction
    endclass

    localparam logic signed [31:0] P_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] P_MIN = 32'sh80000000;
    localparam logic signed [15:0] Q_MAX = 16'sh7fff;
    localparam logic signed [15:0] Q_MIN = 16'sh8000;
    localparam logic signed [15:0] Q_ONE = 16'sh4000;
    localparam logic [16:0]        B_ONE = 17'd65536;
    localparam logic [16:0]        B_TOP = 17'd131071;

    logic             clk;
    logic             rst_n;
    logic             weight_valid;
    logic             weight_ready;
    qws_pkg::weight_t weight;
    logic             vertex_valid;
    logic             vertex_ready;
    qws_pkg::vertex_t vertex;

    skinned_vertex_board board;
    bit                  steady;   // no idling on either side while set

    quaternion_weight_skinning u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .weight_valid (weight_valid),
        .weight_ready (weight_ready),
        .weight       (weight),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex)
    );

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic qws_pkg::weight_t weight_of(
        logic signed [15:0] qx, logic signed [15:0] qy,
        logic signed [15:0] qz, logic signed [15:0] qw,
        logic signed [31:0] jx, logic signed [31:0] jy, logic signed [31:0] jz,
        logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
        logic [16:0] bias, logic last);
        qws_pkg::weight_t wb;
        wb.joint_qx    = qx;
        wb.joint_qy    = qy;
        wb.joint_qz    = qz;
        wb.joint_qw    = qw;
        wb.joint_px    = jx;
        wb.joint_py    = jy;
        wb.joint_pz    = jz;
        wb.weight_px   = px;
        wb.weight_py   = py;
        wb.weight_pz   = pz;
        wb.influence   = bias;
        wb.last_weight = last;
        return wb;
    endfunction

    // Quaternion component: raw, within the unit range, corner or tiny
    function automatic logic signed [15:0] rand_quat();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(0, 32768)) - 16384);
            2:
            begin
                case ($urandom_range(0, 4))
                    0: return Q_MIN;
                    1: return Q_MAX;
                    2: return Q_ONE;
                    3: return -Q_ONE;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'(int'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    // Position component: raw, small, corner or moderate
    function automatic logic signed [31:0] rand_pos();
        case ($urandom_range(0, 3))
            0: return 32'($urandom);
            1: return 32'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return P_MAX;
                    1: return P_MIN;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return 32'(int'($urandom_range(0, 1 << 27)) - (1 << 26));
        endcase
    endfunction

    function automatic logic [16:0] rand_bias();
        case ($urandom_range(0, 3))
            0: return 17'($urandom_range(0, 131071));
            1: return B_ONE;
            2: return 17'($urandom_range(0, 65536));
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 17'd0;
                    1: return B_TOP;
                    2: return 17'd65535;
                    default: return 17'd65537;
                endcase
            end
        endcase
    endfunction

    function automatic int draw_wait();
        return steady ? 0 : int'($urandom_range(0, 5));
    endfunction

    // Offer one weight beat and hold it until taken
    task automatic send_weight(input qws_pkg::weight_t wb);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            weight_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        weight_valid <= 1'b1;
        weight       <= wb;
        @(posedge clk);
        while (!weight_ready)
            @(posedge clk);
        board.add_weight(wb);
    endtask

    // Vertex sink: random stall before each beat, then check it
    initial
    begin : vertex_sink
        int stall;
        vertex_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = draw_wait();
            if (stall > 0)
            begin
                vertex_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            vertex_ready <= 1'b1;
            @(posedge clk);
            while (!vertex_valid)
                @(posedge clk);
            board.check_vertex(vertex);
        end
    end

    // Stimulus
    initial
    begin : stimulus
        qws_pkg::weight_t wb;
        qws_pkg::weight_t heavy;
        int               sent;
        int               len;
        rst_n        = 1'b0;
        weight_valid = 1'b0;
        weight       = '0;
        steady       = 1'b0;
        board        = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Weight that pushes x up and y down by about 2^37 each
        heavy = weight_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MAX, P_MIN, 32'sd0,
                          P_MIN, P_MAX, P_MIN, B_TOP, 1'b0);

        // Directed: zero, identity, corners, bias ends, non-unit quaternions
        send_weight(weight_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 17'd0, 1'b1));
        send_weight(weight_of(0, 0, 0, Q_ONE, 32'sh10000, -32'sh20000, 32'sh30000,
                              32'sh18000, -32'sh8000, 32'sh7fff, B_ONE, 1'b1));
        send_weight(weight_of(0, 0, 16'sd11585, 16'sd11585, 0, 0, 0,
                              32'sha0000, 0, 0, 17'd32768, 1'b0));
        send_weight(weight_of(Q_MAX, Q_MAX, Q_MAX, Q_MAX, P_MAX, P_MAX, P_MAX,
                              P_MAX, P_MAX, P_MAX, B_TOP, 1'b0));
        send_weight(weight_of(Q_MIN, Q_MIN, Q_MIN, Q_MIN, P_MIN, P_MIN, P_MIN,
                              P_MIN, P_MIN, P_MIN, 17'd0, 1'b1));
        send_weight(weight_of(Q_MIN, Q_MAX, 0, Q_MIN, P_MAX, P_MIN, 0,
                              P_MIN, P_MAX, -32'sd1, B_ONE, 1'b1));
        send_weight(weight_of(16'sd1, -16'sd1, Q_ONE, -Q_ONE, -32'sd1, 32'sd1, 0,
                              32'sd1, -32'sd1, P_MIN, 17'd1, 1'b0));
        send_weight(weight_of(0, Q_ONE, 0, 0, 0, 0, 0,
                              P_MAX, 0, P_MIN, 17'd65537, 1'b1));
        send_weight(weight_of(0, 0, 0, Q_ONE, 32'sh10000, 0, 0,
                              32'sh5000, 32'sh6000, -32'sh7000, 17'd21845, 1'b0));
        send_weight(weight_of(Q_ONE, 0, 0, 0, 0, 32'sh10000, 0,
                              -32'sh5000, 32'sh6000, 32'sh7000, 17'd21845, 1'b0));
        send_weight(weight_of(0, -Q_ONE, 0, 0, 0, 0, 32'sh10000,
                              32'sh5000, -32'sh6000, 32'sh7000, 17'd21846, 1'b1));
        wb = heavy;
        wb.last_weight = 1'b1;
        send_weight(wb);
        send_weight(weight_of(Q_MAX, Q_MIN, Q_MAX, Q_MIN, P_MIN, P_MAX, P_MIN,
                              P_MAX, P_MIN, P_MAX, B_ONE, 1'b1));

        // Long vertex: the 48-bit sum saturates both ways
        for (int k = 0; k < 1200; k++)
        begin
            if (k % 150 == 0)
                steady = ($urandom_range(0, 3) == 0);
            wb = heavy;
            wb.last_weight = (k == 1199);
            send_weight(wb);
        end

        // Random vertices, mostly short, some long
        sent = 0;
        while (sent < 800)
        begin
            steady = ($urandom_range(0, 4) == 0);
            len = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 30))
                                              : int'($urandom_range(1, 6));
            for (int k = 0; k < len; k++)
            begin
                wb = weight_of(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
                               rand_pos(), rand_pos(), rand_pos(),
                               rand_pos(), rand_pos(), rand_pos(),
                               rand_bias(), k == len - 1);
                send_weight(wb);
                sent++;
            end
        end
        weight_valid <= 1'b0;
        steady = 1'b0;

        // Drain, then give a stray beat time to show up
        while (board.due_vertices.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog
    initial
    begin
        #8ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/qws_pkg.sv
hw/rtl/qws_mac.sv
hw/rtl/qws_ctrl.sv
hw/rtl/quaternion_weight_skinning.sv
test/quaternion_weight_skinning_tb.sv
